@@ rtl/shunting_yard_postfix_converter_macros.svh @@
// Assertion helpers, clocked on clk and held off during reset.
`ifndef SHUNTING_YARD_POSTFIX_CONVERTER_MACROS_SVH
`define SHUNTING_YARD_POSTFIX_CONVERTER_MACROS_SVH

// Same-cycle implication.
`define SYPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SYPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sypc_pkg.sv @@
`timescale 1ns / 1ps
package sypc_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [2:0] MODE_OPERAND  = 3'd0;
  localparam logic [2:0] MODE_OPERATOR = 3'd1;
  localparam logic [2:0] MODE_LPAREN   = 3'd2;
  localparam logic [2:0] MODE_RPAREN   = 3'd3;
  localparam logic [2:0] MODE_END      = 3'd4;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [2:0] ENTRY_LPAREN = 3'd4;

  localparam logic KIND_OPERAND  = 1'b0;
  localparam logic KIND_OPERATOR = 1'b1;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_RPAREN   = 2'd1;
  localparam logic [1:0] ERR_LPAREN   = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] operand_id;
    logic [1:0]  op_code;
  } in_item_t;

  typedef struct packed {
    logic        token_kind;
    logic [15:0] out_operand;
    logic [1:0]  out_op;
    logic [1:0]  error_code;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TEST,
    S_WAIT,
    S_PUSH,
    S_ERR,
    S_FINISH
  } state_t;

  // Multiply and divide bind tighter than plus and minus; left paren lowest.
  function automatic logic [1:0] prio(input logic [2:0] entry);
    logic [1:0] p;
    if (entry == {1'b0, OP_MUL} || entry == {1'b0, OP_DIV}) begin
      p = 2'd3;
    end else if (entry == {1'b0, OP_ADD} || entry == {1'b0, OP_SUB}) begin
      p = 2'd2;
    end else begin
      p = 2'd1;
    end
    return p;
  endfunction

endpackage

@@ rtl/shunting_yard_postfix_converter.sv @@
// Infix-to-postfix converter with an operator stack held in a simple dual-port
// memory (one write, one registered read of the top entry). One token is
// taken at a time; in_ready is high only between tokens. A push that
// overflows also passes through the error state; each stack entry popped by
// an operator, right paren or end token goes through the top-of-stack read
// loop (S_TEST, S_WAIT). Each result is held in a holding register so that
// the final one can carry last; a slow consumer stalls the pop loop. The
// stack memory is not reset; reset clears its count.
`timescale 1ns / 1ps
`include "shunting_yard_postfix_converter_macros.svh"

module shunting_yard_postfix_converter #(
  parameter int STACK_DEPTH = sypc_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sypc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sypc_pkg::out_item_t out_data
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  sypc_pkg::state_t    state_r, state_nxt;
  sypc_pkg::in_item_t  item_r, item_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                found_r, found_nxt;
  logic [1:0]          err_r, err_nxt;
  logic                hold_v_r, hold_v_nxt;
  sypc_pkg::out_item_t hold_r, hold_nxt;
  logic                out_valid_r, out_valid_nxt;
  sypc_pkg::out_item_t out_r, out_nxt;
  logic [2:0]          rd_data_r;
  logic [2:0]          mem [STACK_DEPTH];

  logic                out_free, slot_ok, cnt_zero, cnt_one, full, top_lp, pop_ok;
  logic                prod_en, finish_en, wr_en;
  sypc_pkg::out_item_t prod_item;
  logic [2:0]          wr_data;
  logic [CW-1:0]       cnt_dec;
  logic [AW-1:0]       rd_addr;

  assign cnt_dec  = cnt_r - CW'(1);
  assign rd_addr  = cnt_dec[AW-1:0];
  assign out_free = !out_valid_r || out_ready;
  assign slot_ok  = !hold_v_r || out_free;
  assign cnt_zero = (cnt_r == '0);
  assign cnt_one  = (cnt_r == CW'(1));
  assign full     = (cnt_r == CW'(STACK_DEPTH));
  assign top_lp   = (rd_data_r == sypc_pkg::ENTRY_LPAREN);
  assign pop_ok   = sypc_pkg::prio({1'b0, item_r.op_code}) <= sypc_pkg::prio(rd_data_r);

  assign in_ready  = (state_r == sypc_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[AW-1:0]] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sypc_pkg::S_IDLE;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      err_r       <= sypc_pkg::ERR_NONE;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      err_r       <= err_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sypc_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sypc_pkg::S_DECODE;
      end
      sypc_pkg::S_DECODE: begin
        case (item_r.mode)
          sypc_pkg::MODE_OPERAND:  if (slot_ok) state_nxt = sypc_pkg::S_FINISH;
          sypc_pkg::MODE_OPERATOR: state_nxt = cnt_zero ? sypc_pkg::S_PUSH : sypc_pkg::S_TEST;
          sypc_pkg::MODE_LPAREN:   state_nxt = sypc_pkg::S_PUSH;
          sypc_pkg::MODE_RPAREN:   state_nxt = cnt_zero ? sypc_pkg::S_ERR : sypc_pkg::S_TEST;
          sypc_pkg::MODE_END:      state_nxt = cnt_zero ? sypc_pkg::S_FINISH : sypc_pkg::S_TEST;
          default:                 state_nxt = sypc_pkg::S_IDLE;
        endcase
      end
      sypc_pkg::S_TEST: begin
        case (item_r.mode)
          sypc_pkg::MODE_OPERATOR: begin
            if (!pop_ok) begin
              state_nxt = sypc_pkg::S_PUSH;
            end else if (slot_ok) begin
              state_nxt = cnt_one ? sypc_pkg::S_PUSH : sypc_pkg::S_WAIT;
            end
          end
          sypc_pkg::MODE_RPAREN: begin
            if (top_lp) begin
              state_nxt = sypc_pkg::S_FINISH;
            end else if (slot_ok) begin
              state_nxt = cnt_one ? sypc_pkg::S_ERR : sypc_pkg::S_WAIT;
            end
          end
          sypc_pkg::MODE_END: begin
            if (top_lp) begin
              state_nxt = cnt_one ? sypc_pkg::S_ERR : sypc_pkg::S_WAIT;
            end else if (slot_ok) begin
              if (!cnt_one) begin
                state_nxt = sypc_pkg::S_WAIT;
              end else begin
                state_nxt = found_r ? sypc_pkg::S_ERR : sypc_pkg::S_FINISH;
              end
            end
          end
          default: state_nxt = sypc_pkg::S_IDLE;
        endcase
      end
      sypc_pkg::S_WAIT: state_nxt = sypc_pkg::S_TEST;
      sypc_pkg::S_PUSH: state_nxt = full ? sypc_pkg::S_ERR : sypc_pkg::S_FINISH;
      sypc_pkg::S_ERR: begin
        if (slot_ok) state_nxt = sypc_pkg::S_FINISH;
      end
      sypc_pkg::S_FINISH: begin
        if (!hold_v_r || out_free) state_nxt = sypc_pkg::S_IDLE;
      end
      default: state_nxt = sypc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item_nxt  = item_r;
    cnt_nxt   = cnt_r;
    found_nxt = found_r;
    err_nxt   = err_r;
    prod_en   = 1'b0;
    prod_item = '0;
    finish_en = 1'b0;
    wr_en     = 1'b0;
    wr_data   = (item_r.mode == sypc_pkg::MODE_LPAREN) ? sypc_pkg::ENTRY_LPAREN
                                                       : {1'b0, item_r.op_code};
    case (state_r)
      sypc_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          found_nxt = 1'b0;
        end
      end
      sypc_pkg::S_DECODE: begin
        if (item_r.mode == sypc_pkg::MODE_OPERAND && slot_ok) begin
          prod_en               = 1'b1;
          prod_item.token_kind  = sypc_pkg::KIND_OPERAND;
          prod_item.out_operand = item_r.operand_id;
        end
        if (item_r.mode == sypc_pkg::MODE_RPAREN && cnt_zero) begin
          err_nxt = sypc_pkg::ERR_RPAREN;
        end
      end
      sypc_pkg::S_TEST: begin
        case (item_r.mode)
          sypc_pkg::MODE_OPERATOR: begin
            if (pop_ok && slot_ok) begin
              prod_en              = 1'b1;
              prod_item.token_kind = sypc_pkg::KIND_OPERATOR;
              prod_item.out_op     = rd_data_r[1:0];
              cnt_nxt              = cnt_dec;
            end
          end
          sypc_pkg::MODE_RPAREN: begin
            if (top_lp) begin
              cnt_nxt = cnt_dec;
            end else if (slot_ok) begin
              prod_en              = 1'b1;
              prod_item.token_kind = sypc_pkg::KIND_OPERATOR;
              prod_item.out_op     = rd_data_r[1:0];
              cnt_nxt              = cnt_dec;
              err_nxt              = sypc_pkg::ERR_RPAREN;
            end
          end
          sypc_pkg::MODE_END: begin
            if (top_lp) begin
              cnt_nxt   = cnt_dec;
              found_nxt = 1'b1;
              err_nxt   = sypc_pkg::ERR_LPAREN;
            end else if (slot_ok) begin
              prod_en              = 1'b1;
              prod_item.token_kind = sypc_pkg::KIND_OPERATOR;
              prod_item.out_op     = rd_data_r[1:0];
              cnt_nxt              = cnt_dec;
              err_nxt              = sypc_pkg::ERR_LPAREN;
            end
          end
          default: ;
        endcase
      end
      sypc_pkg::S_PUSH: begin
        if (full) begin
          err_nxt = sypc_pkg::ERR_OVERFLOW;
        end else begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      sypc_pkg::S_ERR: begin
        if (slot_ok) begin
          prod_en              = 1'b1;
          prod_item.error_code = err_r;
        end
      end
      sypc_pkg::S_FINISH: begin
        finish_en = hold_v_r && out_free;
      end
      default: ;
    endcase
  end

  // Move held result to the output register; the final one gets last.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    hold_v_nxt    = hold_v_r;
    hold_nxt      = hold_r;
    if (prod_en) begin
      if (hold_v_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = hold_r;
      end
      hold_v_nxt = 1'b1;
      hold_nxt   = prod_item;
    end
    if (finish_en) begin
      out_valid_nxt = 1'b1;
      out_nxt       = hold_r;
      out_nxt.last  = 1'b1;
      hold_v_nxt    = 1'b0;
    end
  end

  `SYPC_ASSERT_NOW(a_idle_hold_empty, in_ready, !hold_v_r, "result held while idle")
  `SYPC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(STACK_DEPTH), "stack count beyond depth")
  `SYPC_ASSERT_NEXT(a_finish_flush, finish_en, out_valid_r && out_r.last && !hold_v_r, "final result not delivered")
  `SYPC_ASSERT_NEXT(a_push_full, state_r == sypc_pkg::S_PUSH && full, state_r == sypc_pkg::S_ERR && err_r == sypc_pkg::ERR_OVERFLOW, "overflow not flagged")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;

  localparam int DEPTH = sypc_pkg::STACK_DEPTH_DEF;
  localparam int RANDOM_TOKENS = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 80;
  localparam logic [2:0] MODE_MAX = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  sypc_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  sypc_pkg::out_item_t out_data;

  sypc_pkg::in_item_t  token_feed[$];
  sypc_pkg::in_item_t  scratch[$];
  sypc_pkg::out_item_t postfix_q[$];
  logic [2:0] opstk[DEPTH];
  int        opstk_depth = 0;

  logic      in_taken = 1'b0;
  int        feed_gap = 0;
  int        stall_left = 0;
  bit        feed_calm = 1'b0;
  bit        sink_calm = 1'b0;
  int        tokens_total = 0;
  int        tokens_taken = 0;
  int        results_seen = 0;
  int        error_results = 0;
  int        mismatches = 0;
  int        cycles = 0;

  shunting_yard_postfix_converter #(.STACK_DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [1:0] rank(input logic [2:0] entry);
    if (entry == {1'b0, sypc_pkg::OP_MUL} || entry == {1'b0, sypc_pkg::OP_DIV}) return 2'd3;
    if (entry == sypc_pkg::ENTRY_LPAREN) return 2'd1;
    return 2'd2;
  endfunction

  function automatic sypc_pkg::in_item_t tok(input logic [2:0] m, input logic [15:0] id,
                                             input logic [1:0] op);
    sypc_pkg::in_item_t t;
    t.mode = m;
    t.operand_id = id;
    t.op_code = op;
    return t;
  endfunction

  function automatic logic [15:0] rand_id();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic sypc_pkg::in_item_t rand_tok(input logic [2:0] max_mode);
    return tok(3'($urandom_range(0, max_mode)), rand_id(), 2'($urandom_range(0, 3)));
  endfunction

  task automatic emit(input logic kind, input logic [15:0] opnd, input logic [1:0] op,
                      input logic [1:0] err);
    sypc_pkg::out_item_t r;
    r.token_kind = kind;
    r.out_operand = opnd;
    r.out_op = op;
    r.error_code = err;
    r.last = 1'b0;
    postfix_q.insert(postfix_q.size(), r);
  endtask

  task automatic convert_token(input sypc_pkg::in_item_t t);
    int        first;
    bit        paren_seen;
    logic [2:0] top;
    sypc_pkg::out_item_t r;
    first = postfix_q.size();
    paren_seen = 1'b0;
    case (t.mode)
      sypc_pkg::MODE_OPERAND: begin
        emit(sypc_pkg::KIND_OPERAND, t.operand_id, 2'd0, sypc_pkg::ERR_NONE);
      end
      sypc_pkg::MODE_OPERATOR: begin
        while (opstk_depth > 0 && rank({1'b0, t.op_code}) <= rank(opstk[opstk_depth - 1])) begin
          opstk_depth--;
          emit(sypc_pkg::KIND_OPERATOR, 16'd0, opstk[opstk_depth][1:0], sypc_pkg::ERR_NONE);
        end
        if (opstk_depth < DEPTH) begin
          opstk[opstk_depth] = {1'b0, t.op_code};
          opstk_depth++;
        end else begin
          emit(sypc_pkg::KIND_OPERAND, 16'd0, 2'd0, sypc_pkg::ERR_OVERFLOW);
        end
      end
      sypc_pkg::MODE_LPAREN: begin
        if (opstk_depth < DEPTH) begin
          opstk[opstk_depth] = sypc_pkg::ENTRY_LPAREN;
          opstk_depth++;
        end else begin
          emit(sypc_pkg::KIND_OPERAND, 16'd0, 2'd0, sypc_pkg::ERR_OVERFLOW);
        end
      end
      sypc_pkg::MODE_RPAREN: begin
        while (opstk_depth > 0 && !paren_seen) begin
          opstk_depth--;
          top = opstk[opstk_depth];
          if (top == sypc_pkg::ENTRY_LPAREN) paren_seen = 1'b1;
          else emit(sypc_pkg::KIND_OPERATOR, 16'd0, top[1:0], sypc_pkg::ERR_NONE);
        end
        if (!paren_seen) emit(sypc_pkg::KIND_OPERAND, 16'd0, 2'd0, sypc_pkg::ERR_RPAREN);
      end
      sypc_pkg::MODE_END: begin
        while (opstk_depth > 0) begin
          opstk_depth--;
          top = opstk[opstk_depth];
          if (top == sypc_pkg::ENTRY_LPAREN) paren_seen = 1'b1;
          else emit(sypc_pkg::KIND_OPERATOR, 16'd0, top[1:0], sypc_pkg::ERR_NONE);
        end
        if (paren_seen) emit(sypc_pkg::KIND_OPERAND, 16'd0, 2'd0, sypc_pkg::ERR_LPAREN);
      end
      default: begin
      end
    endcase
    if (postfix_q.size() > first) begin
      r = postfix_q.pop_back();
      r.last = 1'b1;
      postfix_q.insert(postfix_q.size(), r);
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic add_tok(input sypc_pkg::in_item_t t);
    scratch.insert(scratch.size(), t);
  endtask

  task automatic gen_expr(input int lvl);
    int terms;
    terms = $urandom_range(1, 3);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) add_tok(tok(sypc_pkg::MODE_OPERATOR, rand_id(), 2'($urandom_range(0, 3))));
      if (lvl > 0 && $urandom_range(0, 2) == 0) begin
        add_tok(tok(sypc_pkg::MODE_LPAREN, rand_id(), 2'($urandom_range(0, 3))));
        gen_expr(lvl - 1);
        add_tok(tok(sypc_pkg::MODE_RPAREN, rand_id(), 2'($urandom_range(0, 3))));
      end else begin
        add_tok(tok(sypc_pkg::MODE_OPERAND, rand_id(), 2'($urandom_range(0, 3))));
      end
    end
  endtask

  task automatic gen_deep_nest();
    int levels;
    int closes;
    levels = $urandom_range(4, 10);
    for (int i = 0; i < levels; i++) begin
      add_tok(tok(sypc_pkg::MODE_LPAREN, rand_id(), 2'($urandom_range(0, 3))));
      add_tok(tok(sypc_pkg::MODE_OPERAND, rand_id(), 2'($urandom_range(0, 3))));
      add_tok(tok(sypc_pkg::MODE_OPERATOR, rand_id(), 2'($urandom_range(0, 3))));
    end
    add_tok(tok(sypc_pkg::MODE_OPERAND, rand_id(), 2'($urandom_range(0, 3))));
    closes = $urandom_range(0, levels);
    for (int i = 0; i < closes; i++) begin
      add_tok(tok(sypc_pkg::MODE_RPAREN, rand_id(), 2'($urandom_range(0, 3))));
    end
  endtask

  task automatic mutate_scratch();
    int idx;
    idx = $urandom_range(0, scratch.size() - 1);
    if ($urandom_range(0, 1) == 0) scratch.delete(idx);
    else scratch.insert(idx, rand_tok(sypc_pkg::MODE_END));
  endtask

  task automatic feed_tok(input sypc_pkg::in_item_t t);
    token_feed.insert(token_feed.size(), t);
  endtask

  task automatic flush_scratch(input bit add_end);
    if (add_end) add_tok(tok(sypc_pkg::MODE_END, rand_id(), 2'($urandom_range(0, 3))));
    foreach (scratch[i]) feed_tok(scratch[i]);
    scratch.delete();
  endtask

  task automatic build_stimulus();
    int live;
    int r;
    feed_tok(tok(sypc_pkg::MODE_END, 16'h0000, sypc_pkg::OP_ADD));
    feed_tok(tok(sypc_pkg::MODE_OPERAND, 16'hFFFF, sypc_pkg::OP_DIV));
    feed_tok(tok(sypc_pkg::MODE_OPERATOR, 16'hFFFF, sypc_pkg::OP_ADD));
    feed_tok(tok(sypc_pkg::MODE_OPERAND, 16'h0000, sypc_pkg::OP_ADD));
    feed_tok(tok(sypc_pkg::MODE_OPERATOR, 16'h0000, sypc_pkg::OP_MUL));
    feed_tok(tok(sypc_pkg::MODE_LPAREN, 16'hAAAA, sypc_pkg::OP_DIV));
    feed_tok(tok(sypc_pkg::MODE_OPERAND, 16'h8000, sypc_pkg::OP_SUB));
    feed_tok(tok(sypc_pkg::MODE_OPERATOR, 16'h5555, sypc_pkg::OP_SUB));
    feed_tok(tok(sypc_pkg::MODE_OPERAND, 16'h0001, sypc_pkg::OP_MUL));
    feed_tok(tok(sypc_pkg::MODE_OPERATOR, 16'h0000, sypc_pkg::OP_DIV));
    feed_tok(tok(sypc_pkg::MODE_OPERAND, 16'h7FFF, sypc_pkg::OP_ADD));
    feed_tok(tok(sypc_pkg::MODE_RPAREN, 16'hFFFF, sypc_pkg::OP_DIV));
    feed_tok(tok(sypc_pkg::MODE_END, 16'hFFFF, sypc_pkg::OP_DIV));
    feed_tok(tok(sypc_pkg::MODE_RPAREN, 16'h0000, sypc_pkg::OP_ADD));
    feed_tok(tok(sypc_pkg::MODE_OPERATOR, 16'h1234, sypc_pkg::OP_ADD));
    feed_tok(tok(sypc_pkg::MODE_RPAREN, 16'h0000, sypc_pkg::OP_ADD));
    feed_tok(tok(sypc_pkg::MODE_LPAREN, 16'h0000, sypc_pkg::OP_ADD));
    feed_tok(tok(sypc_pkg::MODE_OPERATOR, 16'h0000, sypc_pkg::OP_MUL));
    feed_tok(tok(sypc_pkg::MODE_END, 16'h0000, sypc_pkg::OP_ADD));
    for (int m = int'(sypc_pkg::MODE_END) + 1; m <= int'(MODE_MAX); m++) begin
      feed_tok(tok(3'(m), 16'hFFFF, sypc_pkg::OP_DIV));
    end

    live = 0;
    while (live < RANDOM_TOKENS) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        gen_expr($urandom_range(0, 3));
      end else if (r < 72) begin
        gen_deep_nest();
      end else if (r < 90) begin
        gen_expr($urandom_range(0, 3));
        mutate_scratch();
      end else begin
        repeat ($urandom_range(3, 12)) add_tok(rand_tok(MODE_MAX));
      end
      foreach (scratch[i]) if (scratch[i].mode <= sypc_pkg::MODE_END) live++;
      flush_scratch(r < 97);
      if (r < 97) live++;
    end
    tokens_total = token_feed.size();
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      convert_token(in_data);
      tokens_taken++;
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.error_code != sypc_pkg::ERR_NONE) error_results++;
      if (postfix_q.size() == 0) begin
        $error("unexpected result transaction: kind %0d operand %0d op %0d err %0d last %0d",
               out_data.token_kind, out_data.out_operand, out_data.out_op,
               out_data.error_code, out_data.last);
        mismatches++;
      end else begin
        sypc_pkg::out_item_t want;
        want = postfix_q.pop_front();
        check_field("token_kind", want.token_kind, out_data.token_kind);
        check_field("out_operand", want.out_operand, out_data.out_operand);
        check_field("out_op", want.out_op, out_data.out_op);
        check_field("error_code", want.error_code, out_data.error_code);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (feed_gap > 0) begin
        in_valid <= 1'b0;
        feed_gap--;
      end else if (token_feed.size() > 0) begin
        in_data <= token_feed.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 29) == 0) feed_calm = ~feed_calm;
        feed_gap = feed_calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) sink_calm = ~sink_calm;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = sink_calm ? 0 : pick_gap();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d tokens taken, %0d results pending",
               cycles, tokens_taken, tokens_total, postfix_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (tokens_taken < tokens_total) @(posedge clk);
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Converted %0d infix tokens (operands, operators, parens, end, unused kinds)",
             tokens_total);
    $display("into %0d postfix results, %0d of them error reports", results_seen,
             error_results);
    if (mismatches == 0 && postfix_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
